@@ sv/cpr_pkg.sv @@
// cpr_pkg: shared command and status types for the clock page replacement block
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

  // commands from controller to datapath
  typedef struct packed {
    logic start;         // capture the page of the accepted beat
    logic search;        // scan resident frames, one read per cycle
    logic sweep_step;    // clear reference bit under the hand, advance the hand
    logic vread;         // read the victim frame under the hand
    logic commit_hit;    // set reference bit of the matching frame, emit result
    logic commit_fill;   // write page into the next free frame, emit result
    logic commit_evict;  // replace the victim frame, emit result
  } cpr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic match;         // compared frame holds the page
    logic scan_done;     // every resident frame compared, no match
    logic full;          // all frames in use
    logic ref_at_hand;   // reference bit under the hand is set
    logic out_free;      // result register can take a new beat
  } cpr_status_t;

endpackage

`default_nettype wire

@@ sv/cpr_if.sv @@
// cpr_in_if / cpr_out_if: valid/ready channels of the clock page replacement block
// depends on nothing; widths are set where the channels are instantiated
`timescale 1ns / 1ps
`default_nettype none

interface cpr_in_if #(
  parameter int PAGE_BITS = 20
) ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_BITS-1:0] page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface cpr_out_if #(
  parameter int PAGE_BITS = 20,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4
) ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 evicted;
  logic [PAGE_BITS-1:0] victim_page;
  logic [IDX_W-1:0]     slot;
  logic [IDX_W-1:0]     hand_position;
  logic [CNT_W-1:0]     occupancy;

  modport source (output valid, output hit, output evicted, output victim_page,
                  output slot, output hand_position, output occupancy, input ready);
  modport sink   (input valid, input hit, input evicted, input victim_page,
                  input slot, input hand_position, input occupancy, output ready);
endinterface

`default_nettype wire

@@ sv/cpr_ctrl.sv @@
// cpr_ctrl: state machine sequencing search, fill, sweep and eviction
// depends on cpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl
  import cpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire cpr_status_t sts,
  output cpr_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_FILL,
    ST_SWEEP,
    ST_EVICT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.match) begin
          state_nxt = ST_HIT;
        end else if (sts.scan_done) begin
          state_nxt = sts.full ? ST_SWEEP : ST_FILL;
        end
      end
      ST_HIT: begin
        if (sts.out_free) begin
          cmd.commit_hit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (sts.out_free) begin
          cmd.commit_fill = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (sts.ref_at_hand) begin
          cmd.sweep_step = 1'b1;
        end else begin
          cmd.vread = 1'b1;
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (sts.out_free) begin
          cmd.commit_evict = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/cpr_dp.sv @@
// cpr_dp: frame page memory, reference bits, clock hand, occupancy and result register
// depends on cpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module cpr_dp
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 20,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [PAGE_BITS-1:0] in_page,
  input  wire cpr_cmd_t             cmd,
  output cpr_status_t               sts,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic                      out_hit,
  output logic                      out_evicted,
  output logic [PAGE_BITS-1:0]      out_victim,
  output logic [IDX_W-1:0]          out_slot,
  output logic [IDX_W-1:0]          out_hand,
  output logic [CNT_W-1:0]          out_occ
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAMES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_mem [FRAMES];

  logic [PAGE_BITS-1:0] page_r;
  logic [PAGE_BITS-1:0] rd_data_r;
  logic [CNT_W-1:0]     idx_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_vld_r;
  logic [IDX_W-1:0]     hand_r;
  logic [CNT_W-1:0]     used_r;
  logic [FRAMES-1:0]    ref_r;
  logic                 out_valid_r;

  logic                 match;
  logic                 issue;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [IDX_W-1:0]     used_idx;
  logic [IDX_W-1:0]     hand_inc;

  assign used_idx = used_r[IDX_W-1:0];
  assign hand_inc = (hand_r == LAST_IDX) ? '0 : hand_r + 1'b1;
  assign match    = cmp_vld_r && (rd_data_r == page_r);
  // stop issuing once a match shows so cmp_idx_r keeps the hit frame
  assign issue    = cmd.search && (idx_r != used_r) && !match;
  assign rd_en    = issue || cmd.vread;
  assign rd_addr  = cmd.vread ? hand_r : idx_r[IDX_W-1:0];
  assign wr_en    = cmd.commit_fill || cmd.commit_evict;
  assign wr_addr  = cmd.commit_fill ? used_idx : hand_r;

  assign sts.match       = match;
  assign sts.scan_done   = (idx_r == used_r) && !cmp_vld_r;
  assign sts.full        = (used_r == FULL_CNT);
  assign sts.ref_at_hand = ref_r[hand_r];
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;

  // page memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_mem[wr_addr] <= page_r;
    end
    if (rd_en) begin
      rd_data_r <= page_mem[rd_addr];
      cmp_idx_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page_r <= in_page;
    end
    if (cmd.commit_hit) begin
      out_hit     <= 1'b1;
      out_evicted <= 1'b0;
      out_victim  <= '0;
      out_slot    <= cmp_idx_r;
      out_hand    <= hand_r;
      out_occ     <= used_r;
    end else if (cmd.commit_fill) begin
      out_hit     <= 1'b0;
      out_evicted <= 1'b0;
      out_victim  <= '0;
      out_slot    <= used_idx;
      out_hand    <= hand_r;
      out_occ     <= used_r + 1'b1;
    end else if (cmd.commit_evict) begin
      out_hit     <= 1'b0;
      out_evicted <= 1'b1;
      out_victim  <= rd_data_r;
      out_slot    <= hand_r;
      out_hand    <= hand_r;
      out_occ     <= used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hand_r      <= '0;
      used_r      <= '0;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= issue;
      if (cmd.start) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.sweep_step) begin
        ref_r[hand_r] <= 1'b0;
        hand_r        <= hand_inc;
      end
      if (cmd.commit_hit) begin
        ref_r[cmp_idx_r] <= 1'b1;
      end
      if (cmd.commit_fill) begin
        ref_r[used_idx] <= 1'b1;
        used_r          <= used_r + 1'b1;
      end
      if (cmd.commit_evict) begin
        ref_r[hand_r] <= 1'b1;
      end
      if (cmd.commit_hit || cmd.commit_fill || cmd.commit_evict) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/clock_page_replacement.sv @@
// clock_page_replacement: clock (second chance) page replacement over FRAMES frames
// depends on cpr_pkg, cpr_in_if / cpr_out_if, cpr_ctrl and cpr_dp
//
// usage
//   in_chan carries one page reference per beat; out_chan returns one result beat
//   per reference: hit, evicted, victim_page, slot, hand_position, occupancy
//   a beat moves when valid and ready are both high at a rising edge of clk
// flow
//   one reference is handled at a time; in_chan.ready is high only when idle
//   after the accept, the resident frames are compared one per cycle through
//   the page memory read port (a match ends it early)
//   hit or free-frame fill: committed into the result register once it is free
//   miss with all frames full: the hand sweeps one frame per cycle, clearing set
//   reference bits, until a clear bit is under the hand; the victim is then read
//   and the replacement committed once the result register is free
// reset
//   rst_n low (synchronous) clears reference bits, hand, occupancy and valids;
//   page memory is not cleared, only frames below occupancy are ever read
// stall
//   the result register holds while out_chan.ready is low; the next reference is
//   accepted and searched meanwhile and waits at its commit step for the register
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 20
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cpr_in_if.sink    in_chan,
  cpr_out_if.source out_chan
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);

  cpr_cmd_t    cmd;
  cpr_status_t sts;

  // sequencer: idle, search, then commit of hit / fill or sweep and evict
  cpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and result register
  cpr_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_page     (in_chan.page_number),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_hit     (out_chan.hit),
    .out_evicted (out_chan.evicted),
    .out_victim  (out_chan.victim_page),
    .out_slot    (out_chan.slot),
    .out_hand    (out_chan.hand_position),
    .out_occ     (out_chan.occupancy)
  );

  // occupancy never passes the frame count
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.occupancy <= CNT_W'(FRAMES)))
    else $error("occupancy above frame count");

  // a hit neither evicts nor names a victim
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.hit) |-> (!out_chan.evicted && out_chan.victim_page == '0))
    else $error("hit beat carries eviction");

  // eviction only with all frames in use, and the hand rests on the replaced frame
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.evicted) |->
      (out_chan.occupancy == CNT_W'(FRAMES) && out_chan.slot == out_chan.hand_position))
    else $error("eviction with free frames or hand off victim");

  // one command at most per cycle from the sequencer
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// testbench for clock_page_replacement: page reference beats in, one result beat out each
// depends on cpr_pkg, cpr_in_if / cpr_out_if and the clock_page_replacement rtl
// results are predicted in-order by a frame table tracker and compared field by field
`timescale 1ns / 1ps

module testbench;

  localparam int FRAMES         = 8;
  localparam int PAGE_BITS      = 20;
  localparam int IDX_W          = 3;
  localparam int CNT_W          = 4;
  // the worst case per reference lies far below this
  localparam int STALL_LIMIT    = 4000;
  localparam int SETTLE_CYCLES  = 2 * FRAMES + 8;
  localparam int PHASE_ITEMS    = 600;

  typedef logic [PAGE_BITS-1:0] page_t;

  // one result beat as the block reports it
  typedef struct packed {
    logic             hit;
    logic             evicted;
    page_t            victim_page;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] hand_position;
    logic [CNT_W-1:0] occupancy;
  } ref_outcome_t;

  // tracks frames, reference bits, hand and occupancy; queues the outcome of each reference
  class clock_frame_tracker;
    page_t          frame_page [FRAMES];
    logic           ref_bit    [FRAMES];
    int unsigned    hand;
    int unsigned    used;
    ref_outcome_t   pending_outcomes[$];
    int             errors;

    function new();
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] = '0;
        ref_bit[i]    = 1'b0;
      end
      hand   = 0;
      used   = 0;
      errors = 0;
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    // advance the frame table by one reference and queue what the block must report
    function void take_reference(page_t pg);
      ref_outcome_t oc;
      bit           found;
      int unsigned  s;
      int unsigned  steps;
      oc    = '0;
      found = 0;
      s     = 0;
      for (int i = 0; i < used; i++) begin
        if (!found && frame_page[i] == pg) begin
          found = 1;
          s     = i;
        end
      end
      if (found) begin
        ref_bit[s] = 1'b1;
        oc.hit     = 1'b1;
      end else if (used < FRAMES) begin
        // free frame: next index in fill order
        s             = used;
        frame_page[s] = pg;
        ref_bit[s]    = 1'b1;
        used++;
      end else begin
        // second chance sweep: clear set bits until a clear one is under the hand
        steps = 0;
        while (steps < 2 * FRAMES && ref_bit[hand]) begin
          ref_bit[hand] = 1'b0;
          hand          = (hand + 1) % FRAMES;
          steps++;
        end
        s              = hand;
        oc.evicted     = 1'b1;
        oc.victim_page = frame_page[s];
        frame_page[s]  = pg;
        ref_bit[s]     = 1'b1;
      end
      oc.slot          = IDX_W'(s);
      oc.hand_position = IDX_W'(hand);
      oc.occupancy     = CNT_W'(used);
      pending_outcomes.push_back(oc);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // compare one result beat against the oldest queued outcome
    function void match_result(ref_outcome_t got);
      ref_outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no reference outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("evicted", want.evicted, got.evicted);
      compare_field("victim_page", want.victim_page, got.victim_page);
      compare_field("slot", want.slot, got.slot);
      compare_field("hand_position", want.hand_position, got.hand_position);
      compare_field("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cpr_in_if  #(.PAGE_BITS(PAGE_BITS)) in_chan ();
  cpr_out_if #(.PAGE_BITS(PAGE_BITS), .IDX_W(IDX_W), .CNT_W(CNT_W)) out_chan ();

  clock_page_replacement #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  clock_frame_tracker tracker = new();

  // idle chances in percent, changed per phase
  int send_idle_pct = 24;
  int recv_idle_pct = 73;
  int stall_cycles;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: ready changes at the falling edge, beats are taken at the rising edge
  initial begin
    ref_outcome_t got;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.hit           = out_chan.hit;
        got.evicted       = out_chan.evicted;
        got.victim_page   = out_chan.victim_page;
        got.slot          = out_chan.slot;
        got.hand_position = out_chan.hand_position;
        got.occupancy     = out_chan.occupancy;
        tracker.match_result(got);
      end
    end
  end

  // watchdog: too many cycles without a beat on either channel ends the run
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("clock_page_replacement regression: fail");
    $finish;
  end

  // offer one page reference; entered and left at a falling edge
  // while idling valid is low and the page bus carries noise
  task automatic issue_reference(input page_t pg);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid       <= 1'b0;
      in_chan.page_number <= page_t'($urandom);
      @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.page_number <= pg;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    tracker.take_reference(pg);
    @(negedge clk);
  endtask

  // hold off the sender until every result beat has come back
  task automatic drain_outcomes();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // random references drawn mostly from a drifting working set, so hits
  // and evictions both stay frequent; the rest are full-range pages
  task automatic run_random_phase(input int n_items, input int s_idle, input int r_idle);
    page_t working_set [16];
    int    set_size;
    int    k;
    int    n;
    page_t pg;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_size      = $urandom_range(5, 16);
    for (k = 0; k < 16; k++) working_set[k] = page_t'($urandom);
    for (n = 0; n < n_items; n++) begin
      if ($urandom_range(0, 49) == 0) begin
        working_set[$urandom_range(0, set_size - 1)] = page_t'($urandom);
      end
      if ($urandom_range(0, 99) < 12) begin
        pg = page_t'($urandom);
      end else begin
        pg = working_set[$urandom_range(0, set_size - 1)];
      end
      if ($urandom_range(0, 249) == 0) drain_outcomes();
      issue_reference(pg);
    end
  endtask

  initial begin
    page_t directed_pages [20];
    // fills up the table, hits, then misses with every bit set so the sweep
    // clears all bits and wraps back to where the hand started, then more
    // misses that take second chances frame by frame
    directed_pages = '{
      20'h00000, 20'hFFFFF, 20'h00000, 20'h55555, 20'hAAAAA,
      20'h00001, 20'h80000, 20'h7FFFF, 20'h12345, 20'hFFFFF,
      20'h00000, 20'hABCDE, 20'h55555, 20'h00000, 20'hFFFFF,
      20'h0F0F0, 20'hABCDE, 20'hF0F0F, 20'h80000, 20'h00001
    };
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.page_number <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the first idling mix
    foreach (directed_pages[i]) issue_reference(directed_pages[i]);

    // sender idles little, receiver much; then the other way round; then no idling
    run_random_phase(PHASE_ITEMS, 24, 73);
    drain_outcomes();
    run_random_phase(PHASE_ITEMS, 73, 24);
    drain_outcomes();
    run_random_phase(PHASE_ITEMS, 0, 0);

    in_chan.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("clock_page_replacement regression: pass");
    end else begin
      $display("clock_page_replacement regression: fail");
    end
    $finish;
  end

endmodule

@@ clock_page_replacement.f @@
sv/cpr_pkg.sv
sv/cpr_if.sv
sv/cpr_ctrl.sv
sv/cpr_dp.sv
sv/clock_page_replacement.sv
sim/testbench.sv
